// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; the weight update unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or expression that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression that must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: rtl/stwu_pkg.sv
// Types, constants and the decay table of the synapse trace weight update unit.
package stwu_pkg;

  localparam int TIME_W      = 32;
  localparam int TRACE_W     = 16;
  localparam int WEIGHT_W    = 24;
  localparam int DECAY_DEPTH = 128;
  localparam int DECAY_IDX_W = $clog2(DECAY_DEPTH);

  // Q0.32 value of exp(-1/10), from the truncated alternating Taylor sum.
  localparam logic [63:0] DECAY_BASE = 64'd3886247119;

  localparam logic [TRACE_W:0]   TRACE_ONE  = 17'd256;
  localparam logic [TRACE_W-1:0] TRACE_ONE16 = 16'd256;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 24'sd256;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX   = 24'sh7fffff;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN   = 24'sh800000;

  localparam logic ACTION_PRE  = 1'b0;
  localparam logic ACTION_POST = 1'b1;

  typedef logic [DECAY_DEPTH-1:0][TRACE_W-1:0] decay_table_t;

  // Q0.16 factors exp(-k/10), built by repeated rounded products of the base.
  function automatic decay_table_t build_decay_table();
    decay_table_t tbl;
    logic [63:0]  p;
    logic [63:0]  e;
    p = 64'd1 << 32;
    for (int k = 0; k < DECAY_DEPTH; k++) begin
      if (k > 0) begin
        p = (p * DECAY_BASE + (64'd1 << 31)) >> 32;
      end
      e = (p + 64'd32768) >> 16;
      if (e > 64'd65535) begin
        e = 64'd65535;
      end
      tbl[k] = e[TRACE_W-1:0];
    end
    return tbl;
  endfunction

  localparam decay_table_t DECAY_TABLE = build_decay_table();

endpackage

// File: rtl/synapse_trace_weight_update_unit.sv
// Synapse trace weight update unit: takes one spike word per cycle, returns one
// result word per spike. The unit has two register stages: the input register
// holds the decay factor looked up from the elapsed time of the spiking side,
// and the result register receives the decayed, bumped trace and the updated
// weight after one 16x16 multiply. A spike word passes the input register and then
// the result register before its result is valid, and a new spike word is taken
// every cycle while the result side keeps up. Writing weight_preset loads the
// weight directly; write it only while no spike is in flight.
module synapse_trace_weight_update_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  weight_preset_we,
  input  logic signed [stwu_pkg::WEIGHT_W-1:0]  weight_preset,
  input  logic                                  spike_valid,
  output logic                                  spike_stall,
  input  logic                                  action,
  input  logic        [stwu_pkg::TIME_W-1:0]    spike_time,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [stwu_pkg::WEIGHT_W-1:0]  weight,
  output logic        [stwu_pkg::TRACE_W-1:0]   trace_value
);
  import stwu_pkg::*;

  `include "assert_macros.svh"

  // Per-side state
  logic [TRACE_W-1:0] pre_trace;
  logic [TRACE_W-1:0] post_trace;
  logic [TIME_W-1:0]  pre_last_time;
  logic [TIME_W-1:0]  post_last_time;

  // Input register
  logic               s1_valid;
  logic               s1_action;
  logic               s1_no_decay;
  logic [TRACE_W-1:0] s1_factor;

  logic advance;
  logic spike_take;
  logic result_load;

  logic [TIME_W-1:0]  last_sel;
  logic [TIME_W-1:0]  dt;
  logic               no_decay_next;
  logic               far_gap;
  logic [TRACE_W-1:0] factor_next;

  logic [TRACE_W-1:0]    trace_sel;
  logic [2*TRACE_W-1:0]  product;
  logic [2*TRACE_W:0]    rounded;
  logic [TRACE_W-1:0]    decayed;
  logic [TRACE_W:0]      bumped;
  logic [TRACE_W-1:0]    trace_next;
  logic signed [WEIGHT_W:0] w_ext;
  logic signed [WEIGHT_W:0] t_ext;
  logic signed [WEIGHT_W:0] w_sum;
  logic signed [WEIGHT_W-1:0] weight_next;

  assign advance     = !result_valid || !result_stall;
  assign spike_stall = s1_valid && !advance;
  assign spike_take  = spike_valid && !spike_stall;
  assign result_load = s1_valid && advance;

  // Elapsed time and factor lookup at the input side
  always_comb begin
    last_sel      = (action == ACTION_POST) ? post_last_time : pre_last_time;
    dt            = spike_time - last_sel;
    no_decay_next = (spike_time <= last_sel);
    far_gap       = |dt[TIME_W-1:DECAY_IDX_W];
    factor_next   = far_gap ? '0 : DECAY_TABLE[dt[DECAY_IDX_W-1:0]];
  end

  // Decay, bump and weight update
  always_comb begin
    trace_sel = (s1_action == ACTION_POST) ? post_trace : pre_trace;
    product   = trace_sel * s1_factor;
    rounded   = {1'b0, product} + 33'd32768;
    decayed   = s1_no_decay ? trace_sel : rounded[2*TRACE_W-1:TRACE_W];
    bumped    = {1'b0, decayed} + TRACE_ONE;
    trace_next = bumped[TRACE_W] ? '1 : bumped[TRACE_W-1:0];

    w_ext = {weight[WEIGHT_W-1], weight};
    t_ext = $signed({{(WEIGHT_W+1-TRACE_W){1'b0}}, trace_next});
    w_sum = (s1_action == ACTION_POST) ? (w_ext - t_ext) : (w_ext + t_ext);
    // Saturate on overflow of the 24-bit range
    if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
      weight_next = w_sum[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX;
    end else begin
      weight_next = w_sum[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_trace      <= '0;
      post_trace     <= '0;
      pre_last_time  <= '0;
      post_last_time <= '0;
      weight         <= WEIGHT_RESET;
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (spike_take) begin
        if (action == ACTION_POST) begin
          post_last_time <= spike_time;
        end else begin
          pre_last_time <= spike_time;
        end
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        result_valid <= s1_valid;
      end

      if (weight_preset_we) begin
        weight <= weight_preset;
      end else if (result_load) begin
        weight <= weight_next;
      end

      if (result_load) begin
        if (s1_action == ACTION_POST) begin
          post_trace <= trace_next;
        end else begin
          pre_trace <= trace_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (spike_take) begin
      s1_action   <= action;
      s1_no_decay <= no_decay_next;
      s1_factor   <= factor_next;
    end
    if (result_load) begin
      trace_value <= trace_next;
    end
  end

  `ASSERT_HOLDS(a_trace_bumped, clk, rst, result_valid |-> (trace_value >= TRACE_ONE16))
  `ASSERT_HOLDS(a_load_gives_result, clk, rst, result_load |=> result_valid)
  `ASSERT_HOLDS(a_weight_moves_only_on_update, clk, rst,
                (!weight_preset_we && !result_load) |=> $stable(weight))
  `ASSERT_NEVER(a_take_while_full, clk, rst, spike_take && s1_valid && !advance)

endmodule
